// ----- hdl/sorted_max_priority_queue_core_macros.svh -----
// Assertion macros of the sorted max priority queue RTL.
// Depends on nothing; included by the top-level core, the only module with assertions.
`ifndef SORTED_MAX_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_MAX_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every rising clock edge outside reset.
`define SMPQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("smpq assertion failed");
// A condition that must be followed by a consequence in the next cycle.
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smpq assertion failed");
`else
`define SMPQ_ASSERT(label, clk, rst_n, prop)
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/smpq_pkg.sv -----
// Package of the sorted max priority queue: sizes, operation codes and the
// command struct broadcast to the cell chain. Depends on nothing.
package smpq_pkg;

	localparam int DEPTH = 64;
	localparam int OP_W  = 3;
	localparam int KEY_W = 17;
	localparam int ANS_W = 18;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH     = 3'd0,
		OP_POP      = 3'd1,
		OP_SIZE     = 3'd2,
		OP_EMPTY    = 3'd3,
		OP_PEEK_MAX = 3'd4,
		OP_PEEK_MIN = 3'd5
	} smpq_op_t;

	// Command seen by every cell in the same cycle.
	typedef struct packed {
		logic             push;
		logic             pop;
		logic [KEY_W-1:0] key;
	} smpq_cmd_t;

endpackage

// ----- hdl/smpq_ifs.sv -----
// Valid/ready channel interfaces of the sorted max priority queue.
// Depends on smpq_pkg for the field widths.
interface smpq_req_if;
	import smpq_pkg::*;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [KEY_W-1:0] key;
	modport source (output valid, op, key, input ready);
	modport sink (input valid, op, key, output ready);
endinterface

interface smpq_rsp_if;
	import smpq_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [ANS_W-1:0] answer;
	modport source (output valid, answer, input ready);
	modport sink (input valid, answer, output ready);
endinterface

// ----- hdl/smpq_cell.sv -----
// One cell of the sorted key chain: holds one key and trades it with its
// neighbors on push and pop. Depends on smpq_pkg.
module smpq_cell (
	input  logic                           clk,
	input  smpq_pkg::smpq_cmd_t            cmd,
	input  logic                           occ,
	input  logic                           prev_ge,
	input  logic [smpq_pkg::KEY_W-1:0]     prev_key,
	input  logic [smpq_pkg::KEY_W-1:0]     next_key,
	output logic [smpq_pkg::KEY_W-1:0]     key_q,
	output logic                           ge
);
	import smpq_pkg::*;

	// The stored key stays in place when it is at least the new key.
	assign ge = occ && (key_q >= cmd.key);

	// Push: the first smaller cell takes the new key, later cells shift down.
	// Pop: every cell but the last takes its lower neighbor's key.
	always_ff @(posedge clk) begin
		if (cmd.push && !ge) begin
			key_q <= prev_ge ? cmd.key : prev_key;
		end else if (cmd.pop) begin
			key_q <= next_key;
		end
	end

endmodule

// ----- hdl/sorted_max_priority_queue_core.sv -----
// Top level of the sorted max priority queue: a chain of key cells, the
// entry count, a minimum register and the result register.
// Depends on smpq_pkg, smpq_ifs, smpq_cell and the assertion macros.
//
//   channel | dir | fields       | accepted when
//   req     | in  | op, key      | req.valid && req.ready
//   rsp     | out | answer       | rsp.valid && rsp.ready
//
// The whole chain compares against the new key in parallel, so push and pop
// finish in the cycle they are accepted and the next item need not wait for them.
// Results appear in the output register the cycle after acceptance.
// req.ready is low only while a result waits and rsp.ready is low.
// Reset clears the entry count and the result valid flag; no clearing pass.
`include "sorted_max_priority_queue_core_macros.svh"

module sorted_max_priority_queue_core (
	input  logic    clk,
	input  logic    arst_n,
	smpq_req_if.sink   req,
	smpq_rsp_if.source rsp
);
	import smpq_pkg::*;

	logic [CNT_W-1:0]        count_q;
	logic [KEY_W-1:0]        min_q;
	logic                    out_valid_q;
	logic signed [ANS_W-1:0] answer_q;
	logic [KEY_W-1:0]        keys [DEPTH];
	logic                    ge   [DEPTH];
	logic                    occ  [DEPTH];
	logic                    acc;
	logic                    empty;
	logic                    full;
	logic                    has_res;
	logic signed [ANS_W-1:0] ans;
	smpq_cmd_t               cmd;

	assign acc   = req.valid && req.ready;
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	// Decode the item into a chain command and an optional result.
	always_comb begin
		cmd.push = 1'b0;
		cmd.pop  = 1'b0;
		cmd.key  = req.key;
		has_res  = 1'b0;
		ans      = '1;
		case (smpq_op_t'(req.op))
			OP_PUSH: begin
				cmd.push = acc && !full;
			end
			OP_POP: begin
				cmd.pop = acc && !empty;
				has_res = 1'b1;
				ans     = empty ? '1 : signed'({1'b0, keys[0]});
			end
			OP_SIZE: begin
				has_res = 1'b1;
				ans     = signed'(ANS_W'(count_q));
			end
			OP_EMPTY: begin
				has_res = 1'b1;
				ans     = empty ? ANS_W'(1) : '0;
			end
			OP_PEEK_MAX: begin
				has_res = 1'b1;
				ans     = empty ? '1 : signed'({1'b0, keys[0]});
			end
			OP_PEEK_MIN: begin
				has_res = 1'b1;
				ans     = empty ? '1 : signed'({1'b0, min_q});
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

	// The chain of cells, each linked to its upper and lower neighbor where it has one.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_first
			// Nothing sits above the first cell, so it behaves as if its upper
			// neighbor kept its place and takes the new key when it is smaller.
			smpq_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.occ      (occ[i]),
				.prev_ge  (1'b1),
				.prev_key ('0),
				.next_key (keys[i+1]),
				.key_q    (keys[i]),
				.ge       (ge[i])
			);
		end else if (i == DEPTH - 1) begin : g_last
			smpq_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.occ      (occ[i]),
				.prev_ge  (ge[i-1]),
				.prev_key (keys[i-1]),
				.next_key (keys[i]),
				.key_q    (keys[i]),
				.ge       (ge[i])
			);
		end else begin : g_mid
			smpq_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.occ      (occ[i]),
				.prev_ge  (ge[i-1]),
				.prev_key (keys[i-1]),
				.next_key (keys[i+1]),
				.key_q    (keys[i]),
				.ge       (ge[i])
			);
		end
	end

	// Entry count follows pushes and pops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// The smallest key only changes on a push; a pop removes the largest.
	always_ff @(posedge clk) begin
		if (cmd.push && (empty || (req.key <= min_q))) begin
			min_q <= req.key;
		end
	end

	// Result register; a new item is taken while the old result leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && has_res) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && has_res) begin
			answer_q <= ans;
		end
	end

	assign req.ready  = !out_valid_q || rsp.ready;
	assign rsp.valid  = out_valid_q;
	assign rsp.answer = answer_q;

	// The count never passes the capacity.
	`SMPQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))
	// A push that is not dropped raises the count by one.
	`SMPQ_ASSERT_NEXT(a_push_count, clk, arst_n, cmd.push, count_q == $past(count_q) + CNT_W'(1))
	// The two top cells stay in descending order.
	`SMPQ_ASSERT(a_top_sorted, clk, arst_n, (count_q < CNT_W'(2)) || (keys[0] >= keys[1]))
	// The tracked minimum never exceeds the maximum.
	`SMPQ_ASSERT(a_min_le_max, clk, arst_n, empty || (min_q <= keys[0]))

endmodule

// ----- verif/sorted_max_priority_queue_core_test.sv -----
// Testbench of sorted_max_priority_queue_core: directed and random operations
// against a sorted-array model of the queue, with bursty input and output stalls.
// Depends on smpq_pkg, the smpq_req_if/smpq_rsp_if interfaces and the core itself.
module sorted_max_priority_queue_core_test;
	import smpq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1650;
	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;
	localparam logic signed [ANS_W-1:0] NO_KEY = '1;
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_SELDOM,
		RX_PERIODIC
	} rx_mode_t;

	logic clk;
	logic arst_n;

	smpq_req_if req_ch ();
	smpq_rsp_if rsp_ch ();

	sorted_max_priority_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model of the queue: keys held in descending order.
	logic [KEY_W-1:0] held_keys [DEPTH];
	int unsigned held_count;

	logic signed [ANS_W-1:0] answers_due[$];
	int mismatch_count;
	int items_sent;
	int burst_left;
	int cycle_count;
	rx_mode_t rx_mode;
	int rx_mode_left;

	always #5 clk = ~clk;

	// Update the model with one accepted item and queue the answer it gives.
	task automatic model_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
		int slot;
		int idx;
		logic signed [ANS_W-1:0] answer;
		bit gives_answer;
		gives_answer = 1'b1;
		answer = NO_KEY;
		case (op)
			OP_PUSH: begin
				gives_answer = 1'b0;
				if (held_count < DEPTH) begin
					slot = 0;
					while (slot < held_count && held_keys[slot] >= key)
						slot++;
					for (idx = held_count; idx > slot; idx--)
						held_keys[idx] = held_keys[idx - 1];
					held_keys[slot] = key;
					held_count++;
				end
			end
			OP_POP: begin
				if (held_count != 0) begin
					answer = {1'b0, held_keys[0]};
					for (idx = 1; idx < held_count; idx++)
						held_keys[idx - 1] = held_keys[idx];
					held_count--;
				end
			end
			OP_SIZE: answer = ANS_W'(held_count);
			OP_EMPTY: answer = (held_count == 0) ? ANS_W'(1) : ANS_W'(0);
			OP_PEEK_MAX: begin
				if (held_count != 0)
					answer = {1'b0, held_keys[0]};
			end
			OP_PEEK_MIN: begin
				if (held_count != 0)
					answer = {1'b0, held_keys[held_count - 1]};
			end
			default: gives_answer = 1'b0;
		endcase
		if (gives_answer)
			answers_due.push_back(answer);
	endtask

	task automatic note_mismatch(input string what, input logic signed [ANS_W-1:0] expected,
			input logic signed [ANS_W-1:0] actual);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s: expected answer %0d, got %0d", $realtime, what, expected,
				actual);
	endtask

	// Check each delivered answer, then record each accepted item in the model.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (answers_due.size() == 0)
					note_mismatch("answer with none pending", NO_KEY, rsp_ch.answer);
				else if (rsp_ch.answer !== answers_due[0])
					note_mismatch("wrong answer", answers_due.pop_front(), rsp_ch.answer);
				else
					void'(answers_due.pop_front());
			end
			if (req_ch.valid && req_ch.ready)
				model_request(req_ch.op, req_ch.key);
		end
	end

	// Result stalls: rsp.ready follows a random mode, picked anew when its countdown runs out.
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_mode_left <= $urandom_range(16, 160);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			RX_ALWAYS: rsp_ch.ready <= 1'b1;
			RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			RX_SELDOM: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ch.ready <= (cycle_count % 5 != 0);
		endcase
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Send one item; a new burst starts after a random gap, sometimes none.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				req_ch.op <= OP_W'($urandom);
				req_ch.key <= KEY_W'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.key <= key;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		burst_left--;
		if (op <= OP_PEEK_MIN)
			items_sent++;
	endtask

	// Hold the input off until every pending answer has been delivered.
	task automatic wait_for_answers();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	function automatic logic [KEY_W-1:0] random_key();
		case ($urandom_range(0, 5))
			0: return KEY_W'($urandom_range(0, 7));
			1: return ($urandom_range(0, 1) != 0) ? KEY_MAX : '0;
			2: return KEY_MAX - KEY_W'($urandom_range(0, 7));
			default: return KEY_W'($urandom);
		endcase
	endfunction

	// Every query on an empty queue, and the two unused codes.
	task automatic test_empty_queue();
		send_item(OP_POP, '0);
		send_item(OP_PEEK_MAX, KEY_MAX);
		send_item(OP_PEEK_MIN, '0);
		send_item(OP_SIZE, '0);
		send_item(OP_EMPTY, '0);
		send_item(OP_UNUSED_LO, KEY_MAX);
		send_item(OP_UNUSED_HI, '0);
		send_item(OP_SIZE, KEY_MAX);
	endtask

	// Smallest, largest and alternating-bit keys, popped back in order.
	task automatic test_key_extremes();
		send_item(OP_PUSH, '0);
		send_item(OP_PUSH, KEY_MAX);
		send_item(OP_PUSH, 17'h15555);
		send_item(OP_PUSH, 17'h0AAAA);
		send_item(OP_SIZE, '0);
		send_item(OP_EMPTY, '0);
		send_item(OP_PEEK_MAX, '0);
		send_item(OP_PEEK_MIN, '0);
		repeat (3) send_item(OP_POP, '0);
		send_item(OP_PEEK_MIN, '0);
		send_item(OP_POP, '0);
		send_item(OP_POP, '0);
	endtask

	// Copies of one key are all kept.
	task automatic test_equal_keys();
		repeat (3) send_item(OP_PUSH, 17'd7);
		send_item(OP_POP, '0);
		send_item(OP_SIZE, '0);
		send_item(OP_POP, '0);
		send_item(OP_POP, '0);
	endtask

	// Fill past capacity so the extra pushes are dropped, then drain past empty.
	task automatic test_full_queue();
		int pops;
		repeat (DEPTH + $urandom_range(1, 4)) send_item(OP_PUSH, random_key());
		send_item(OP_SIZE, '0);
		send_item(OP_EMPTY, '0);
		send_item(OP_PEEK_MAX, '0);
		send_item(OP_PEEK_MIN, '0);
		pops = DEPTH + $urandom_range(1, 3);
		repeat (pops) begin
			send_item(OP_POP, random_key());
			if ($urandom_range(0, 7) == 0)
				send_item(($urandom_range(0, 1) != 0) ? OP_PEEK_MIN : OP_SIZE, random_key());
		end
	endtask

	// A stretch of mixed operations; the push share decides where the count drifts.
	task automatic test_random_mix();
		int push_pct;
		int pick;
		logic [OP_W-1:0] op;
		push_pct = $urandom_range(20, 75);
		repeat ($urandom_range(20, 80)) begin
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				op = OP_PUSH;
			else if (pick < 97)
				op = OP_W'($urandom_range(OP_POP, OP_PEEK_MIN));
			else
				op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
			send_item(op, random_key());
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_PUSH;
		req_ch.key = '0;
		rsp_ch.ready = 1'b0;
		rx_mode = RX_ALWAYS;
		rx_mode_left = 0;
		held_count = 0;
		mismatch_count = 0;
		items_sent = 0;
		burst_left = 0;
		cycle_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_key_extremes();
		test_equal_keys();
		wait_for_answers();

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 4) == 0)
				test_full_queue();
			else
				test_random_mix();
			if ($urandom_range(0, 3) == 0)
				wait_for_answers();
		end

		wait_for_answers();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && answers_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/smpq_pkg.sv
hdl/smpq_ifs.sv
hdl/smpq_cell.sv
hdl/sorted_max_priority_queue_core.sv
verif/sorted_max_priority_queue_core_test.sv
